// File: rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants of the road segment projector.
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned NumW      = 64;
  localparam int unsigned DenW      = 45;
  localparam int unsigned QuotW     = 17;
  localparam int unsigned MulW      = 34;

  localparam logic [CfgIdxW-1:0] CfgDepthScale = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenW    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgScreenH    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRoadHalfW  = 2'd3;

  localparam logic [15:0] DepthScaleRst = 16'd3437;
  localparam logic [11:0] ScreenWRst    = 12'd800;
  localparam logic [11:0] ScreenHRst    = 12'd600;
  localparam logic [15:0] RoadHalfWRst  = 16'd2000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EDGE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                   start;
    logic signed [NumW-1:0] num;
    logic [DenW-1:0]        den;
  } div_req_t;

endpackage

`default_nettype wire

// File: rtl/rsp_mul.sv
// ----------------------------------------------------------------------------
// rsp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_mul (
  input  wire logic                             clk_i,
  input  wire logic signed [rsp_pkg::MulW-1:0]  a_i,
  input  wire logic signed [rsp_pkg::MulW-1:0]  b_i,
  output logic signed [rsp_pkg::NumW-1:0]       p_o
);
  import rsp_pkg::*;

  logic signed [2*MulW-1:0] prod;
  logic signed [NumW-1:0]   p_q;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= prod[NumW-1:0];
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: rtl/rsp_div.sv
// ----------------------------------------------------------------------------
// rsp_div
// Restoring divider: round half away from zero, saturate to 16 bits signed.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rsp_pkg::div_req_t req_i,
  output logic                   done_o,
  output logic signed [15:0]     res_o
);
  import rsp_pkg::*;

  logic                 busy_q, done_q, neg_q, ovf_q;
  logic [NumW:0]        rem_q;
  logic [DenW+16:0]     dsh_q;
  logic [QuotW-1:0]     q_q;
  logic [4:0]           cnt_q;
  logic [NumW-1:0]      mag;
  logic [NumW:0]        nn;
  logic [DenW:0]        dd;
  logic                 ge;

  assign mag = req_i.num[NumW-1] ? NumW'(-req_i.num) : NumW'(req_i.num);
  assign nn  = {mag, 1'b0} + (NumW+1)'(req_i.den);
  assign dd  = {req_i.den, 1'b0};
  assign ge  = rem_q >= (NumW+1)'(dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 5'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[NumW-1];
      ovf_q <= nn[NumW:QuotW] >= (NumW+1-QuotW)'(dd);
      rem_q <= nn;
      dsh_q <= {dd, 16'd0};
      q_q   <= '0;
      cnt_q <= 5'(QuotW - 1);
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - (NumW+1)'(dsh_q);
      end
      q_q   <= {q_q[QuotW-2:0], ge};
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_comb begin
    if (neg_q) begin
      res_o = (ovf_q || q_q > 17'd32768) ? 16'sh8000 : 16'(17'd0 - q_q);
    end else begin
      res_o = (ovf_q || q_q > 17'd32767) ? 16'sh7fff : q_q[15:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// File: rtl/road_segment_projector.sv
// ----------------------------------------------------------------------------
// road_segment_projector
// Projects near/far road segment edges to screen space with curve and clip.
// ----------------------------------------------------------------------------
// Segments: one at a time; in_stall_o holds the input while a segment is in work.
//   Each edge uses the shared 17-step divider three times and the shared multiplier eight times.
// Reset: asynchronous, active low; control and config registers return to defaults, clip line 600.
`default_nettype none

module road_segment_projector (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [rsp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rsp_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  frame_start_i,
  input  wire logic signed [21:0]    camera_x_i,
  input  wire logic signed [31:0]    camera_y_i,
  input  wire logic signed [31:0]    camera_z_i,
  input  wire logic signed [13:0]    start_slope_i,
  input  wire logic signed [31:0]    near_y_i,
  input  wire logic signed [31:0]    far_y_i,
  input  wire logic signed [31:0]    near_z_i,
  input  wire logic signed [31:0]    far_z_i,
  input  wire logic signed [4:0]     curve_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [15:0]         near_screen_x_o,
  output logic signed [15:0]         near_screen_y_o,
  output logic signed [15:0]         near_half_width_o,
  output logic signed [15:0]         far_screen_x_o,
  output logic signed [15:0]         far_screen_y_o,
  output logic signed [15:0]         far_half_width_o,
  output logic                       visible_o,
  output logic signed [15:0]         clip_line_o
);
  import rsp_pkg::*;

  state_e state_q, state_d;

  logic [15:0] ds_q, rhw_q;
  logic [11:0] sw_q, sh_q;

  logic signed [21:0] cam_x_q;
  logic signed [31:0] cam_y_q, cam_z_q;
  logic signed [39:0] offset_q;
  logic signed [23:0] slope_q;
  logic signed [15:0] clip_q;

  logic signed [31:0] near_y_q, far_y_q, near_z_q, far_z_q;
  logic signed [4:0]  curve_q;

  logic [3:0] step_q;
  logic [1:0] sel_q;
  logic       edge_q;
  logic       ok_near_q;
  logic       vis_q;

  logic [31:0]        tmp_q;
  logic signed [63:0] tx_q, ty_q, cw_q, cy_q, hwn_q;
  logic signed [15:0] sx_q [2];
  logic signed [15:0] sy_q [2];
  logic signed [15:0] hw_q [2];

  logic out_valid_q;
  logic signed [15:0] o_nsx_q, o_nsy_q, o_nhw_q, o_fsx_q, o_fsy_q, o_fhw_q, o_clip_q;
  logic o_vis_q;

  logic               accept, out_go;
  logic signed [31:0] y_sel, z_sel;
  logic signed [32:0] ry, rz, rx, nrz;
  logic signed [39:0] off_adj;
  logic signed [31:0] off_int;
  logic               rz_pos;
  logic signed [MulW-1:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] nx, ny;
  div_req_t           div_req;
  logic               div_done;
  logic signed [15:0] div_res, res_m;
  logic signed [40:0] off_sum;
  logic signed [24:0] sl_sum;
  logic signed [39:0] off_sat;
  logic signed [23:0] sl_sat;
  logic               vis;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_go     = !out_valid_q || !out_stall_i;

  assign y_sel   = edge_q ? far_y_q : near_y_q;
  assign z_sel   = edge_q ? far_z_q : near_z_q;
  assign ry      = 33'(y_sel) - 33'(cam_y_q);
  assign rz      = 33'(z_sel) - 33'(cam_z_q);
  assign nrz     = 33'(near_z_q) - 33'(cam_z_q);
  assign off_adj = offset_q[39] ? offset_q + 40'sd255 : offset_q;
  assign off_int = off_adj[39:8];
  assign rx      = 33'(off_int) - 33'(cam_x_q);
  assign rz_pos  = !rz[32] && (rz != 33'sd0);

  always_comb begin
    case (step_q[3:1])
      3'd0:    begin mul_a = $signed(MulW'(ds_q));       mul_b = $signed(MulW'(sw_q)); end
      3'd1:    begin mul_a = $signed(MulW'(tmp_q));      mul_b = MulW'(rx);            end
      3'd2:    begin mul_a = $signed(MulW'(ds_q));       mul_b = $signed(MulW'(sh_q)); end
      3'd3:    begin mul_a = $signed(MulW'(tmp_q));      mul_b = MulW'(ry);            end
      3'd4:    begin mul_a = $signed(MulW'(sw_q[11:1])); mul_b = MulW'(rz);            end
      3'd5:    begin mul_a = $signed(MulW'(sh_q[11:1])); mul_b = MulW'(rz);            end
      3'd6:    begin mul_a = $signed(MulW'(ds_q));       mul_b = $signed(MulW'(rhw_q)); end
      default: begin mul_a = $signed(MulW'(tmp_q));      mul_b = $signed(MulW'(sw_q)); end
    endcase
  end

  rsp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign nx = (cw_q <<< 13) + tx_q;
  assign ny = (cy_q <<< 13) - ty_q;

  always_comb begin
    div_req.start = (state_q == ST_DIV_GO);
    div_req.den   = {rz[31:0], 13'd0};
    case (sel_q)
      2'd0:    div_req.num = nx;
      2'd1:    div_req.num = ny;
      default: div_req.num = hwn_q;
    endcase
  end

  rsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .res_o  (div_res)
  );

  assign res_m = rz_pos ? div_res : 16'sd0;

  assign off_sum = 41'(offset_q) + 41'(slope_q);
  assign off_sat = (off_sum[40] != off_sum[39]) ?
                   (off_sum[40] ? 40'sh80_0000_0000 : 40'sh7f_ffff_ffff) : off_sum[39:0];
  assign sl_sum  = 25'(slope_q) + 25'($signed({curve_q, 8'd0}));
  assign sl_sat  = (sl_sum[24] != sl_sum[23]) ?
                   (sl_sum[24] ? 24'sh80_0000 : 24'sh7f_ffff) : sl_sum[23:0];

  assign vis = ok_near_q && rz_pos
            && ($signed({nrz, 12'd0}) > $signed(45'(ds_q)))
            && (sy_q[1] < clip_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_MUL;
      ST_MUL:      if (step_q == 4'd15) state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_d = (sel_q == 2'd2) ? ST_EDGE : ST_DIV_GO;
      ST_EDGE:     state_d = edge_q ? ST_FINISH : ST_MUL;
      ST_FINISH:   if (out_go) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ds_q        <= DepthScaleRst;
      sw_q        <= ScreenWRst;
      sh_q        <= ScreenHRst;
      rhw_q       <= RoadHalfWRst;
      cam_x_q     <= '0;
      cam_y_q     <= '0;
      cam_z_q     <= '0;
      offset_q    <= '0;
      slope_q     <= '0;
      clip_q      <= 16'(ScreenHRst);
      step_q      <= '0;
      sel_q       <= '0;
      edge_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgDepthScale: ds_q  <= cfg_data_i;
          CfgScreenW:    sw_q  <= cfg_data_i[11:0];
          CfgScreenH:    sh_q  <= cfg_data_i[11:0];
          CfgRoadHalfW:  rhw_q <= cfg_data_i;
          default:       ;
        endcase
      end
      if (accept) begin
        step_q <= '0;
        sel_q  <= '0;
        edge_q <= 1'b0;
        if (frame_start_i) begin
          cam_x_q  <= camera_x_i;
          cam_y_q  <= camera_y_i;
          cam_z_q  <= camera_z_i;
          slope_q  <= 24'(start_slope_i);
          offset_q <= '0;
          clip_q   <= $signed({4'd0, sh_q});
        end
      end
      if (state_q == ST_MUL) begin
        step_q <= step_q + 4'd1;
      end
      if (state_q == ST_DIV_WAIT && div_done) begin
        sel_q <= (sel_q == 2'd2) ? 2'd0 : sel_q + 2'd1;
      end
      if (state_q == ST_EDGE) begin
        step_q <= '0;
        if (!edge_q) begin
          offset_q <= off_sat;
          edge_q   <= 1'b1;
        end else begin
          slope_q <= sl_sat;
          if (vis) begin
            clip_q <= sy_q[1];
          end
        end
      end
      if (state_q == ST_FINISH && out_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      near_y_q <= near_y_i;
      far_y_q  <= far_y_i;
      near_z_q <= near_z_i;
      far_z_q  <= far_z_i;
      curve_q  <= curve_i;
    end
    if (state_q == ST_MUL && step_q[0]) begin
      case (step_q[3:1])
        3'd1:    tx_q  <= mul_p;
        3'd3:    ty_q  <= mul_p;
        3'd4:    cw_q  <= mul_p;
        3'd5:    cy_q  <= mul_p;
        3'd7:    hwn_q <= mul_p;
        default: tmp_q <= mul_p[31:0];
      endcase
    end
    if (state_q == ST_DIV_WAIT && div_done) begin
      case (sel_q)
        2'd0:    sx_q[edge_q] <= res_m;
        2'd1:    sy_q[edge_q] <= res_m;
        default: hw_q[edge_q] <= res_m;
      endcase
    end
    if (state_q == ST_EDGE) begin
      if (!edge_q) begin
        ok_near_q <= rz_pos;
      end else begin
        vis_q <= vis;
      end
    end
    if (state_q == ST_FINISH && out_go) begin
      o_nsx_q  <= sx_q[0];
      o_nsy_q  <= sy_q[0];
      o_nhw_q  <= hw_q[0];
      o_fsx_q  <= sx_q[1];
      o_fsy_q  <= sy_q[1];
      o_fhw_q  <= hw_q[1];
      o_vis_q  <= vis_q;
      o_clip_q <= clip_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign near_screen_x_o   = o_nsx_q;
  assign near_screen_y_o   = o_nsy_q;
  assign near_half_width_o = o_nhw_q;
  assign far_screen_x_o    = o_fsx_q;
  assign far_screen_y_o    = o_fsy_q;
  assign far_half_width_o  = o_fhw_q;
  assign visible_o         = o_vis_q;
  assign clip_line_o       = o_clip_q;

endmodule

`default_nettype wire

// File: rtl/rsp_checker.sv
// ----------------------------------------------------------------------------
// rsp_checker
// Port-level checks of the road segment projector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [15:0] near_half_width_o,
  input wire logic signed [15:0] far_screen_y_o,
  input wire logic               visible_o,
  input wire logic signed [15:0] clip_line_o
);

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a segment is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(clip_line_o)
                                   && $stable(far_screen_y_o) && $stable(visible_o))
    else $error("stalled result changed");

  a_clip_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && visible_o |-> clip_line_o == far_screen_y_o)
    else $error("visible segment did not raise clip line");

  a_width_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !near_half_width_o[15])
    else $error("negative near half width");

endmodule

bind road_segment_projector rsp_checker u_rsp_checker (.*);

`default_nettype wire
